/* design/bcpc_pkg.sv */
// Shared types, constants and lookup tables of the commutation power control block.
`timescale 1ns / 1ps

package bcpc_pkg;

    localparam int PERIOD_W = 16;
    localparam int QUAL_W   = 8;
    localparam int RAMP_W   = 7;
    localparam int STEP_W   = 3;
    localparam int IDX_W    = 2;

    localparam logic [7:0] RAMP_LAST = 8'd127;

    localparam logic [1:0] MODE_HALT  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [IDX_W-1:0] REG_HALT_PERIOD   = 2'd0;
    localparam logic [IDX_W-1:0] REG_START_PERIOD  = 2'd1;
    localparam logic [IDX_W-1:0] REG_KICK_POWER    = 2'd2;
    localparam logic [IDX_W-1:0] REG_QUALIFY_COUNT = 2'd3;

    localparam logic [PERIOD_W-1:0] HALT_PERIOD_RST   = 16'd11000;
    localparam logic [PERIOD_W-1:0] START_PERIOD_RST  = 16'd12000;
    localparam logic [PERIOD_W-1:0] KICK_POWER_RST    = 16'd2000;
    localparam logic [QUAL_W-1:0]   QUALIFY_COUNT_RST = 8'd20;

    typedef struct packed {
        logic [PERIOD_W-1:0] halt_period;
        logic [PERIOD_W-1:0] start_period;
        logic [PERIOD_W-1:0] kick_power;
        logic [QUAL_W-1:0]   qualify_count;
    } cfg_t;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend_hi;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    localparam logic [15:0] TARGET_ROM [0:255] = '{
        16'd2500, 16'd2415, 16'd2335, 16'd2261, 16'd2191, 16'd2126, 16'd2064, 16'd2006,
        16'd1951, 16'd1899, 16'd1849, 16'd1802, 16'd1758, 16'd1715, 16'd1675, 16'd1636,
        16'd1600, 16'd1564, 16'd1531, 16'd1498, 16'd1467, 16'd1438, 16'd1409, 16'd1382,
        16'd1355, 16'd1330, 16'd1306, 16'd1282, 16'd1259, 16'd1237, 16'd1216, 16'd1196,
        16'd1176, 16'd1157, 16'd1138, 16'd1120, 16'd1103, 16'd1086, 16'd1070, 16'd1054,
        16'd1038, 16'd1024, 16'd1009, 16'd995, 16'd981, 16'd968, 16'd955, 16'd942,
        16'd930, 16'd918, 16'd906, 16'd895, 16'd883, 16'd873, 16'd862, 16'd852,
        16'd842, 16'd832, 16'd822, 16'd813, 16'd804, 16'd795, 16'd786, 16'd777,
        16'd769, 16'd760, 16'd752, 16'd745, 16'd737, 16'd729, 16'd722, 16'd715,
        16'd707, 16'd700, 16'd694, 16'd687, 16'd680, 16'd674, 16'd668, 16'd661,
        16'd655, 16'd649, 16'd643, 16'd638, 16'd632, 16'd626, 16'd621, 16'd615,
        16'd610, 16'd605, 16'd600, 16'd595, 16'd590, 16'd585, 16'd580, 16'd576,
        16'd571, 16'd566, 16'd562, 16'd557, 16'd553, 16'd549, 16'd545, 16'd540,
        16'd536, 16'd532, 16'd528, 16'd525, 16'd521, 16'd517, 16'd513, 16'd509,
        16'd506, 16'd502, 16'd499, 16'd495, 16'd492, 16'd488, 16'd485, 16'd482,
        16'd479, 16'd475, 16'd472, 16'd469, 16'd466, 16'd463, 16'd460, 16'd457,
        16'd454, 16'd451, 16'd448, 16'd445, 16'd443, 16'd440, 16'd437, 16'd435,
        16'd432, 16'd429, 16'd427, 16'd424, 16'd422, 16'd419, 16'd417, 16'd414,
        16'd412, 16'd409, 16'd407, 16'd405, 16'd403, 16'd400, 16'd398, 16'd396,
        16'd394, 16'd391, 16'd389, 16'd387, 16'd385, 16'd383, 16'd381, 16'd379,
        16'd377, 16'd375, 16'd373, 16'd371, 16'd369, 16'd367, 16'd365, 16'd363,
        16'd361, 16'd360, 16'd358, 16'd356, 16'd354, 16'd353, 16'd351, 16'd349,
        16'd347, 16'd346, 16'd344, 16'd342, 16'd341, 16'd339, 16'd337, 16'd336,
        16'd334, 16'd333, 16'd331, 16'd330, 16'd328, 16'd327, 16'd325, 16'd324,
        16'd322, 16'd321, 16'd319, 16'd318, 16'd316, 16'd315, 16'd314, 16'd312,
        16'd311, 16'd309, 16'd308, 16'd307, 16'd305, 16'd304, 16'd303, 16'd302,
        16'd300, 16'd299, 16'd298, 16'd296, 16'd295, 16'd294, 16'd293, 16'd292,
        16'd290, 16'd289, 16'd288, 16'd287, 16'd286, 16'd285, 16'd283, 16'd282,
        16'd281, 16'd280, 16'd279, 16'd278, 16'd277, 16'd276, 16'd275, 16'd274,
        16'd273, 16'd271, 16'd270, 16'd269, 16'd268, 16'd267, 16'd266, 16'd265,
        16'd264, 16'd263, 16'd262, 16'd261, 16'd261, 16'd260, 16'd259, 16'd258,
        16'd257, 16'd256, 16'd255, 16'd254, 16'd253, 16'd252, 16'd251, 16'd250
    };

    localparam logic [15:0] RAMP_ROM [0:127] = '{
        16'd49999, 16'd48120, 16'd46376, 16'd44755, 16'd43243, 16'd41830, 16'd40506, 16'd39263,
        16'd38095, 16'd36994, 16'd35955, 16'd34972, 16'd34042, 16'd33160, 16'd32323, 16'd31527,
        16'd30769, 16'd30046, 16'd29357, 16'd28699, 16'd28070, 16'd27467, 16'd26890, 16'd26337,
        16'd25806, 16'd25296, 16'd24806, 16'd24334, 16'd23880, 16'd23443, 16'd23021, 16'd22614,
        16'd22222, 16'd21843, 16'd21476, 16'd21122, 16'd20779, 16'd20447, 16'd20125, 16'd19814,
        16'd19512, 16'd19219, 16'd18934, 16'd18658, 16'd18390, 16'd18130, 16'd17877, 16'd17630,
        16'd17391, 16'd17158, 16'd16931, 16'd16710, 16'd16494, 16'd16284, 16'd16080, 16'd15880,
        16'd15686, 16'd15496, 16'd15311, 16'd15130, 16'd14953, 16'd14780, 16'd14611, 16'd14446,
        16'd14285, 16'd14128, 16'd13973, 16'd13822, 16'd13675, 16'd13530, 16'd13389, 16'd13250,
        16'd13114, 16'd12981, 16'd12851, 16'd12723, 16'd12598, 16'd12475, 16'd12355, 16'd12237,
        16'd12121, 16'd12007, 16'd11895, 16'd11786, 16'd11678, 16'd11573, 16'd11469, 16'd11367,
        16'd11267, 16'd11169, 16'd11072, 16'd10977, 16'd10884, 16'd10792, 16'd10702, 16'd10613,
        16'd10526, 16'd10440, 16'd10355, 16'd10272, 16'd10191, 16'd10110, 16'd10031, 16'd9953,
        16'd9876, 16'd9800, 16'd9726, 16'd9653, 16'd9580, 16'd9509, 16'd9439, 16'd9370,
        16'd9302, 16'd9235, 16'd9169, 16'd9103, 16'd9039, 16'd8976, 16'd8913, 16'd8852,
        16'd8791, 16'd8731, 16'd8672, 16'd8613, 16'd8556, 16'd8499, 16'd8443, 16'd8387
    };

endpackage

/* design/bcpc_if.sv */
// Handshake channel interfaces for commutation items and power results.
`timescale 1ns / 1ps

interface bcpc_item_if;
    logic        valid;
    logic        ready;
    logic [15:0] period_ticks;
    logic [7:0]  throttle;
    logic        restart;

    modport source (output valid, period_ticks, throttle, restart, input ready);
    modport sink   (input valid, period_ticks, throttle, restart, output ready);
endinterface

interface bcpc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] power_ticks;
    logic [15:0] hold_ticks;
    logic [1:0]  mode;
    logic [2:0]  phase_step;
    logic [14:0] blanking_ticks;

    modport source (output valid, power_ticks, hold_ticks, mode, phase_step, blanking_ticks,
                    input ready);
    modport sink   (input valid, power_ticks, hold_ticks, mode, phase_step, blanking_ticks,
                    output ready);
endinterface

/* design/bcpc_cfg.sv */
// Configuration register bank written through the plain write port.
`timescale 1ns / 1ps

module bcpc_cfg
    import bcpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_index,
    input  logic [PERIOD_W-1:0] wr_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_HALT_PERIOD:   cfg_next.halt_period   = wr_data;
                REG_START_PERIOD:  cfg_next.start_period  = wr_data;
                REG_KICK_POWER:    cfg_next.kick_power    = wr_data;
                REG_QUALIFY_COUNT: cfg_next.qualify_count = wr_data[QUAL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.halt_period   <= HALT_PERIOD_RST;
            cfg_reg.start_period  <= START_PERIOD_RST;
            cfg_reg.kick_power    <= KICK_POWER_RST;
            cfg_reg.qualify_count <= QUALIFY_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/bcpc_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bcpc_div
    import bcpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    output logic                done,
    output logic [PERIOD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PERIOD_W + 1);

    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] quo_reg, quo_next;
    logic [PERIOD_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [PERIOD_W:0]   shifted;
    logic                fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = req.dividend_hi;
            quo_next = '0;
            den_next = req.divisor;
            cnt_next = CNT_W'(PERIOD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? PERIOD_W'(shifted - {1'b0, den_reg}) : shifted[PERIOD_W-1:0];
            quo_next  = {quo_reg[PERIOD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/bldc_commutation_power_control_core.sv */
// Flow: an item that needs no division goes from S_IDLE straight to S_DONE; in running mode
// with period above target it passes S_DIV (16 divider steps, multiply), S_CAP (clamp), S_DONE (result load).
// Items are taken only in S_IDLE, so a new item waits until the last result is loaded, also
// while the shift-subtract divider runs; the result register frees the input side meanwhile.
// Reset: asynchronous, active low; mode halt, counters, ramp, phase and hold cleared.
`timescale 1ns / 1ps

module bldc_commutation_power_control_core
    import bcpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_index,
    input  logic [PERIOD_W-1:0] wr_data,
    bcpc_item_if.sink           item,
    bcpc_result_if.source       result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_CAP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int PROD_W = 2 * PERIOD_W + 1;

    cfg_t                cfg;
    div_req_t            div_req;
    logic                div_done;
    logic [PERIOD_W-1:0] div_quo;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          mode_reg, mode_next;
    logic [RAMP_W-1:0]   ramp_reg, ramp_next;
    logic [QUAL_W-1:0]   kick_reg, kick_next;
    logic [QUAL_W-1:0]   run_reg, run_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PERIOD_W-1:0] hold_reg, hold_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] power_reg, power_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                o_valid_reg, o_valid_next;
    logic [PERIOD_W-1:0] o_power_reg, o_power_next;
    logic [PERIOD_W-1:0] o_hold_reg, o_hold_next;
    logic [1:0]          o_mode_reg, o_mode_next;
    logic [STEP_W-1:0]   o_step_reg, o_step_next;
    logic [PERIOD_W-2:0] o_blank_reg, o_blank_next;

    logic                accept;
    logic                take;
    logic                load;

    logic [PERIOD_W-1:0] tgt;
    logic [1:0]          a_mode;
    logic [RAMP_W-1:0]   a_ramp;
    logic [QUAL_W-1:0]   a_kick;
    logic [QUAL_W-1:0]   a_run;
    logic [PERIOD_W-1:0] a_hold;
    logic [PERIOD_W-1:0] a_power;
    logic                a_div;
    logic [QUAL_W-1:0]   kick_inc;
    logic [QUAL_W-1:0]   run_base;
    logic [QUAL_W-1:0]   run_inc;
    logic                kick_ok;
    logic                run_ok;
    logic [PERIOD_W:0]   factor;
    logic [PROD_W-11:0]  scaled;

    bcpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    bcpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign take       = o_valid_reg && result.ready;
    assign load       = (state_reg == S_DONE) && (!o_valid_reg || result.ready);

    assign tgt = TARGET_ROM[item.throttle];

    // Mode step for the item at the input
    always_comb
    begin
        a_mode   = mode_reg;
        a_ramp   = ramp_reg;
        a_kick   = kick_reg;
        a_run    = run_reg;
        a_hold   = hold_reg;
        a_power  = '0;
        a_div    = 1'b0;
        kick_ok  = (item.period_ticks < cfg.start_period) &&
                   (item.period_ticks > (cfg.start_period >> 3));
        run_ok   = (item.period_ticks < cfg.halt_period) &&
                   (item.period_ticks > (cfg.halt_period >> 3));
        kick_inc = (kick_reg == '1) ? kick_reg : kick_reg + 1'b1;
        run_base = kick_ok ? run_reg : '0;
        run_inc  = (run_base == '1) ? run_base : run_base + 1'b1;

        priority if (mode_reg == MODE_RUN)
        begin
            if (item.period_ticks > cfg.halt_period)
            begin
                a_kick = '0;
                a_run  = '0;
                a_mode = MODE_HALT;
            end
            else if (item.period_ticks > tgt)
            begin
                a_div = 1'b1;
            end
        end
        else if (mode_reg == MODE_START)
        begin
            a_ramp  = ramp_reg + 1'b1;
            a_hold  = RAMP_ROM[a_ramp];
            a_power = {2'b00, item.period_ticks[PERIOD_W-1:2]};
            if (({1'b0, a_ramp} == RAMP_LAST) || (a_ramp == '0))
            begin
                a_mode = MODE_RUN;
            end
        end
        else
        begin
            a_kick  = kick_ok ? kick_inc : '0;
            a_power = (a_kick > cfg.qualify_count) ? cfg.kick_power : '0;
            a_run   = run_ok ? run_inc : '0;
            a_mode  = (a_run > cfg.qualify_count) ? MODE_RUN : MODE_HALT;
        end

        if (item.restart)
        begin
            a_ramp = '0;
            a_mode = MODE_START;
        end
    end

    assign div_req.start       = accept && a_div;
    assign div_req.dividend_hi = tgt;
    assign div_req.divisor     = item.period_ticks;

    assign factor = {1'b1, {PERIOD_W{1'b0}}} - {1'b0, div_quo};
    assign scaled = prod_reg[PROD_W-1:10];

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        ramp_next   = ramp_reg;
        kick_next   = kick_reg;
        run_next    = run_reg;
        step_next   = step_reg;
        hold_next   = hold_reg;
        period_next = period_reg;
        power_next  = power_reg;
        prod_next   = prod_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = a_mode;
                    ramp_next   = a_ramp;
                    kick_next   = a_kick;
                    run_next    = a_run;
                    hold_next   = a_hold;
                    power_next  = a_power;
                    period_next = item.period_ticks;
                    step_next   = (step_reg >= STEP_W'(5)) ? '0 : step_reg + 1'b1;
                    state_next  = a_div ? S_DIV : S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    prod_next  = {{(PERIOD_W + 1){1'b0}}, period_reg} *
                                 {{PERIOD_W{1'b0}}, factor};
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                power_next = (scaled > {{(PROD_W - 10 - PERIOD_W){1'b0}}, period_reg}) ?
                             period_reg : scaled[PERIOD_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_power_next = o_power_reg;
        o_hold_next  = o_hold_reg;
        o_mode_next  = o_mode_reg;
        o_step_next  = o_step_reg;
        o_blank_next = o_blank_reg;
        if (load)
        begin
            o_valid_next = 1'b1;
            o_power_next = power_reg;
            o_hold_next  = hold_reg;
            o_mode_next  = mode_reg;
            o_step_next  = step_reg;
            o_blank_next = period_reg[PERIOD_W-1:1];
        end
        else if (take)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_HALT;
            ramp_reg    <= '0;
            kick_reg    <= '0;
            run_reg     <= '0;
            step_reg    <= '0;
            hold_reg    <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            ramp_reg    <= ramp_next;
            kick_reg    <= kick_next;
            run_reg     <= run_next;
            step_reg    <= step_next;
            hold_reg    <= hold_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg  <= period_next;
        power_reg   <= power_next;
        prod_reg    <= prod_next;
        o_power_reg <= o_power_next;
        o_hold_reg  <= o_hold_next;
        o_mode_reg  <= o_mode_next;
        o_step_reg  <= o_step_next;
        o_blank_reg <= o_blank_next;
    end

    assign result.valid          = o_valid_reg;
    assign result.power_ticks    = o_power_reg;
    assign result.hold_ticks     = o_hold_reg;
    assign result.mode           = o_mode_reg;
    assign result.phase_step     = o_step_reg;
    assign result.blanking_ticks = o_blank_reg;

`ifndef ASSERT_OFF
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the division state");

    a_cap_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAP) |=> (power_reg <= period_reg))
        else $error("running on-time exceeds the period");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.phase_step <= STEP_W'(5)))
        else $error("phase index out of range");

    a_load_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !$past(o_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result raised without a finished item");
`endif

endmodule
